FILE: design/t8pwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package t8pwm_pkg;

  // Item kinds (carried on s_tuser)
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_ACK   = 2'd3;

  // Register map
  localparam logic [2:0] ADDR_COUNT  = 3'd0;
  localparam logic [2:0] ADDR_CMP_A  = 3'd1;
  localparam logic [2:0] ADDR_CMP_B  = 3'd2;
  localparam logic [2:0] ADDR_CTRL_A = 3'd3;
  localparam logic [2:0] ADDR_CTRL_B = 3'd4;
  localparam logic [2:0] ADDR_MASK   = 3'd5;
  localparam logic [2:0] ADDR_FLAGS  = 3'd6;

  // Pin actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_TOGGLE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_SET    = 2'd3;

  // Waveform modes
  localparam logic [2:0] MODE_NORMAL    = 3'd0;
  localparam logic [2:0] MODE_PC_FF     = 3'd1;
  localparam logic [2:0] MODE_CTC       = 3'd2;
  localparam logic [2:0] MODE_FAST_FF   = 3'd3;
  localparam logic [2:0] MODE_PC_CMP_A  = 3'd5;
  localparam logic [2:0] MODE_FAST_CMP_A = 3'd7;

  // Clock select
  localparam logic [2:0] CS_STOP    = 3'd0;
  localparam logic [2:0] CS_DIV1    = 3'd1;
  localparam logic [2:0] CS_DIV8    = 3'd2;
  localparam logic [2:0] CS_DIV64   = 3'd3;
  localparam logic [2:0] CS_DIV256  = 3'd4;
  localparam logic [2:0] CS_DIV1024 = 3'd5;
  localparam logic [2:0] CS_FALL    = 3'd6;

  // Flag bit positions
  localparam int FLAG_OVF  = 0;
  localparam int FLAG_CMPA = 1;
  localparam int FLAG_CMPB = 2;

  // Interrupt vectors
  localparam logic [1:0] VEC_CMPA = 2'd0;
  localparam logic [1:0] VEC_CMPB = 2'd1;
  localparam logic [1:0] VEC_OVF  = 2'd2;

  localparam int PRESCALE_W = 10;

  function automatic logic is_phase_mode(input logic [2:0] mode);
    return (mode == MODE_PC_FF) || (mode == MODE_PC_CMP_A);
  endfunction

  function automatic logic is_fast_mode(input logic [2:0] mode);
    return (mode == MODE_FAST_FF) || (mode == MODE_FAST_CMP_A);
  endfunction

  function automatic logic is_pwm_mode(input logic [2:0] mode);
    return is_phase_mode(mode) || is_fast_mode(mode);
  endfunction

  function automatic logic apply_action(input logic pin, input logic [1:0] act);
    logic res;
    case (act)
      ACT_TOGGLE: res = ~pin;
      ACT_CLEAR:  res = 1'b0;
      ACT_SET:    res = 1'b1;
      default:    res = pin;
    endcase
    return res;
  endfunction

  // Swap clear/set on the down slope of phase-correct modes
  function automatic logic [1:0] match_action(input logic [1:0] act, input logic phase,
                                              input logic up);
    logic [1:0] res;
    res = act;
    if (phase && !up) begin
      if (act == ACT_CLEAR) begin
        res = ACT_SET;
      end else if (act == ACT_SET) begin
        res = ACT_CLEAR;
      end
    end
    return res;
  endfunction

  function automatic logic [PRESCALE_W:0] prescale_div(input logic [2:0] cs);
    logic [PRESCALE_W:0] res;
    case (cs)
      CS_DIV8:    res = 11'd8;
      CS_DIV64:   res = 11'd64;
      CS_DIV256:  res = 11'd256;
      CS_DIV1024: res = 11'd1024;
      default:    res = 11'd1;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/timer8_pwm_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// 8-bit timer/counter with PWM, driven by a stream of items. Each input
// transaction is a clock tick, a register read, a register write or an
// interrupt acknowledge, and produces exactly one result transaction in the
// next cycle. One item is taken every cycle while the result side does not
// stall; the whole state update is a single pass of combinational logic from
// the state registers and the accepted item into the next state and the output
// register. The output register frees as it is taken, so s_tready stays high
// while m_tready is high or the output register is empty; a stalled result
// holds only the input side. The power-down bit is written through the cfg
// port, which is always ready outside reset.
module timer8_pwm_counter (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: power-down bit
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  // Input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // address[2:0], write_data[10:3], t_pin[11], zeros
  input  wire logic [1:0]  s_tuser,  // operation[1:0]
  // Results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata   // rd_value[7:0], pin_a_level[8], pin_b_level[9],
                                     // irq_pending[10], irq_vector[12:11], ack_taken[13],
                                     // ack_vector[15:14], match_a_event[16],
                                     // match_b_event[17], overflow_event[18], zeros
);

  // Architectural state
  logic       powered_down;
  logic [7:0] count, count_next;
  logic [7:0] cmp_a_act, cmp_a_act_next;
  logic [7:0] cmp_b_act, cmp_b_act_next;
  logic [7:0] cmp_a_buf, cmp_a_buf_next;
  logic [7:0] cmp_b_buf, cmp_b_buf_next;
  logic [7:0] ctrl_a, ctrl_a_next;
  logic [7:0] ctrl_b, ctrl_b_next;
  logic [7:0] irq_mask, irq_mask_next;
  logic [2:0] irq_flags, irq_flags_next;
  logic       count_up, count_up_next;
  logic [t8pwm_pkg::PRESCALE_W-1:0] prescale, prescale_next;
  logic       last_pin, last_pin_next;
  logic       pin_a, pin_a_next;
  logic       pin_b, pin_b_next;

  // Output register
  logic        out_valid;
  logic [23:0] out_data;

  // Item fields
  logic [1:0] op;
  logic [2:0] addr;
  logic [7:0] wdata;
  logic       t_pin;

  assign op    = s_tuser;
  assign addr  = s_tdata[2:0];
  assign wdata = s_tdata[10:3];
  assign t_pin = s_tdata[11];

  logic accept;
  assign s_tready  = ~rst & (~out_valid | m_tready);
  assign accept    = s_tvalid & s_tready;
  assign cfg_ready = ~rst;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // -------------------------------------------------------------------------
  // One counter step: computed every cycle, applied only when the prescaler
  // or the external edge detector fires.
  // -------------------------------------------------------------------------
  logic [2:0] mode;
  logic       phase, fast;
  logic [7:0] top, cnt_inc;
  logic [7:0] st_count, st_cmp_a, st_cmp_b;
  logic       st_up, st_ovf, st_match_a, st_match_b, st_pin_a, st_pin_b;
  logic [1:0] act_a, act_b;

  assign mode    = {ctrl_b[3], ctrl_a[1:0]};
  assign phase   = t8pwm_pkg::is_phase_mode(mode);
  assign fast    = t8pwm_pkg::is_fast_mode(mode);
  assign act_a   = ctrl_a[7:6];
  assign act_b   = ctrl_a[5:4];
  assign cnt_inc = count + 8'd1;
  assign top     = (mode == t8pwm_pkg::MODE_CTC || mode == t8pwm_pkg::MODE_PC_CMP_A ||
                    mode == t8pwm_pkg::MODE_FAST_CMP_A) ? cmp_a_act : 8'hFF;

  always_comb begin
    st_count = count;
    st_up    = count_up;
    st_cmp_a = cmp_a_act;
    st_cmp_b = cmp_b_act;
    st_ovf   = 1'b0;
    if (phase) begin
      if (count_up) begin
        if (count == top) begin
          // Already at top: turn round
          st_up = 1'b0;
          if (count != 8'd0) begin
            st_count = count - 8'd1;
          end
        end else begin
          st_count = cnt_inc;
          if (cnt_inc == top) begin
            // Reaching top: turn round and take the buffered compares
            st_up    = 1'b0;
            st_cmp_a = cmp_a_buf;
            st_cmp_b = cmp_b_buf;
          end
        end
      end else if (count == 8'd0) begin
        st_up    = 1'b1;
        st_ovf   = 1'b1;
        st_count = 8'd1;
      end else begin
        st_count = count - 8'd1;
      end
    end else if (fast) begin
      if (count == top) begin
        st_ovf   = 1'b1;
        st_cmp_a = cmp_a_buf;
        st_cmp_b = cmp_b_buf;
        st_count = 8'd0;
      end else begin
        st_count = cnt_inc;
      end
    end else begin
      if (count == top) begin
        st_ovf   = (mode != t8pwm_pkg::MODE_CTC);
        st_count = 8'd0;
      end else begin
        st_count = cnt_inc;
      end
    end

    st_match_a = (st_count == st_cmp_a);
    st_match_b = (st_count == st_cmp_b);
    st_pin_a   = st_match_a ?
                 t8pwm_pkg::apply_action(pin_a, t8pwm_pkg::match_action(act_a, phase, st_up)) :
                 pin_a;
    st_pin_b   = st_match_b ?
                 t8pwm_pkg::apply_action(pin_b, t8pwm_pkg::match_action(act_b, phase, st_up)) :
                 pin_b;

    // Fast PWM bottom: invert the compare action
    if (fast && st_count == 8'd0) begin
      if (act_a == t8pwm_pkg::ACT_CLEAR) begin
        st_pin_a = 1'b1;
      end else if (act_a == t8pwm_pkg::ACT_SET) begin
        st_pin_a = 1'b0;
      end
      if (act_b == t8pwm_pkg::ACT_CLEAR) begin
        st_pin_b = 1'b1;
      end else if (act_b == t8pwm_pkg::ACT_SET) begin
        st_pin_b = 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Item decode and next state
  // -------------------------------------------------------------------------
  logic [2:0] cs;
  logic [t8pwm_pkg::PRESCALE_W-1:0] pc_inc;
  logic       do_step, direct;
  logic [2:0] mode_wr;
  logic [2:0] pend_old, pend_new;
  logic [7:0] rd;
  logic       taken, irq;
  logic [1:0] ack_vec, irq_vec;
  logic       ev_a, ev_b, ev_ovf;

  assign cs      = ctrl_b[2:0];
  assign pc_inc  = prescale + {{(t8pwm_pkg::PRESCALE_W-1){1'b0}}, 1'b1};
  assign direct  = ~t8pwm_pkg::is_pwm_mode(mode) | (cs == t8pwm_pkg::CS_STOP);
  assign mode_wr = {wdata[3], ctrl_a[1:0]};
  assign pend_old = irq_flags & irq_mask[2:0];

  always_comb begin
    count_next     = count;
    cmp_a_act_next = cmp_a_act;
    cmp_b_act_next = cmp_b_act;
    cmp_a_buf_next = cmp_a_buf;
    cmp_b_buf_next = cmp_b_buf;
    ctrl_a_next    = ctrl_a;
    ctrl_b_next    = ctrl_b;
    irq_mask_next  = irq_mask;
    irq_flags_next = irq_flags;
    count_up_next  = count_up;
    prescale_next  = prescale;
    last_pin_next  = last_pin;
    pin_a_next     = pin_a;
    pin_b_next     = pin_b;
    do_step        = 1'b0;
    rd             = 8'd0;
    taken          = 1'b0;
    ack_vec        = t8pwm_pkg::VEC_CMPA;
    ev_a           = 1'b0;
    ev_b           = 1'b0;
    ev_ovf         = 1'b0;

    case (op)
      t8pwm_pkg::OP_TICK: begin
        if (!powered_down && cs != t8pwm_pkg::CS_STOP) begin
          if (cs inside {[t8pwm_pkg::CS_DIV1:t8pwm_pkg::CS_DIV1024]}) begin
            prescale_next = pc_inc;
            if ({1'b0, pc_inc} >= t8pwm_pkg::prescale_div(cs) || pc_inc == '0) begin
              prescale_next = '0;
              do_step       = 1'b1;
            end
          end else begin
            do_step = (cs == t8pwm_pkg::CS_FALL) ? (last_pin & ~t_pin) : (~last_pin & t_pin);
            last_pin_next = t_pin;
          end
        end
        if (do_step) begin
          count_next     = st_count;
          count_up_next  = st_up;
          cmp_a_act_next = st_cmp_a;
          cmp_b_act_next = st_cmp_b;
          pin_a_next     = st_pin_a;
          pin_b_next     = st_pin_b;
          irq_flags_next = irq_flags | {st_match_b, st_match_a, st_ovf};
          ev_a           = st_match_a;
          ev_b           = st_match_b;
          ev_ovf         = st_ovf;
        end
      end
      t8pwm_pkg::OP_READ: begin
        case (addr)
          t8pwm_pkg::ADDR_COUNT:  rd = count;
          t8pwm_pkg::ADDR_CMP_A:  rd = cmp_a_buf;
          t8pwm_pkg::ADDR_CMP_B:  rd = cmp_b_buf;
          t8pwm_pkg::ADDR_CTRL_A: rd = ctrl_a;
          t8pwm_pkg::ADDR_CTRL_B: rd = ctrl_b;
          t8pwm_pkg::ADDR_MASK:   rd = irq_mask;
          t8pwm_pkg::ADDR_FLAGS:  rd = {5'd0, irq_flags};
          default:                rd = 8'd0;
        endcase
      end
      t8pwm_pkg::OP_WRITE: begin
        case (addr)
          t8pwm_pkg::ADDR_COUNT: count_next = wdata;
          t8pwm_pkg::ADDR_CMP_A: begin
            cmp_a_buf_next = wdata;
            if (direct) begin
              cmp_a_act_next = wdata;
            end
          end
          t8pwm_pkg::ADDR_CMP_B: begin
            cmp_b_buf_next = wdata;
            if (direct) begin
              cmp_b_act_next = wdata;
            end
          end
          t8pwm_pkg::ADDR_CTRL_A: ctrl_a_next = wdata;
          t8pwm_pkg::ADDR_CTRL_B: begin
            // Force strobes are not stored; they act only outside PWM modes
            ctrl_b_next = {2'b00, wdata[5:0]};
            if (!t8pwm_pkg::is_pwm_mode(mode_wr)) begin
              if (wdata[7]) begin
                pin_a_next = t8pwm_pkg::apply_action(pin_a, act_a);
              end
              if (wdata[6]) begin
                pin_b_next = t8pwm_pkg::apply_action(pin_b, act_b);
              end
            end
          end
          t8pwm_pkg::ADDR_MASK:  irq_mask_next = wdata;
          t8pwm_pkg::ADDR_FLAGS: irq_flags_next = irq_flags & ~wdata[2:0];
          default: ;
        endcase
      end
      default: begin
        // Acknowledge: clear the highest-priority pending source
        if (pend_old[t8pwm_pkg::FLAG_CMPA]) begin
          taken   = 1'b1;
          ack_vec = t8pwm_pkg::VEC_CMPA;
          irq_flags_next[t8pwm_pkg::FLAG_CMPA] = 1'b0;
        end else if (pend_old[t8pwm_pkg::FLAG_CMPB]) begin
          taken   = 1'b1;
          ack_vec = t8pwm_pkg::VEC_CMPB;
          irq_flags_next[t8pwm_pkg::FLAG_CMPB] = 1'b0;
        end else if (pend_old[t8pwm_pkg::FLAG_OVF]) begin
          taken   = 1'b1;
          ack_vec = t8pwm_pkg::VEC_OVF;
          irq_flags_next[t8pwm_pkg::FLAG_OVF] = 1'b0;
        end
      end
    endcase
  end

  // Interrupt state after the item
  assign pend_new = irq_flags_next & irq_mask_next[2:0];
  assign irq      = |pend_new;

  always_comb begin
    if (pend_new[t8pwm_pkg::FLAG_CMPA]) begin
      irq_vec = t8pwm_pkg::VEC_CMPA;
    end else if (pend_new[t8pwm_pkg::FLAG_CMPB]) begin
      irq_vec = t8pwm_pkg::VEC_CMPB;
    end else if (pend_new[t8pwm_pkg::FLAG_OVF]) begin
      irq_vec = t8pwm_pkg::VEC_OVF;
    end else begin
      irq_vec = t8pwm_pkg::VEC_CMPA;
    end
  end

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      powered_down <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      powered_down <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_a_act <= '0;
      cmp_b_act <= '0;
      cmp_a_buf <= '0;
      cmp_b_buf <= '0;
      ctrl_a    <= '0;
      ctrl_b    <= '0;
      irq_mask  <= '0;
      irq_flags <= '0;
      count_up  <= 1'b1;
      prescale  <= '0;
      last_pin  <= 1'b0;
      pin_a     <= 1'b0;
      pin_b     <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      cmp_a_act <= cmp_a_act_next;
      cmp_b_act <= cmp_b_act_next;
      cmp_a_buf <= cmp_a_buf_next;
      cmp_b_buf <= cmp_b_buf_next;
      ctrl_a    <= ctrl_a_next;
      ctrl_b    <= ctrl_b_next;
      irq_mask  <= irq_mask_next;
      irq_flags <= irq_flags_next;
      count_up  <= count_up_next;
      prescale  <= prescale_next;
      last_pin  <= last_pin_next;
      pin_a     <= pin_a_next;
      pin_b     <= pin_b_next;
    end
  end

  // Hold the result until taken; load a new one on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {5'd0, ev_ovf, ev_b, ev_a, ack_vec, taken, irq_vec, irq,
                   pin_b_next, pin_a_next, rd};
    end
  end

endmodule

`default_nettype wire

FILE: design/t8pwm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module t8pwm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Idle interrupt state shows vector zero
  a_irq_vec: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[10] |-> m_tdata[12:11] == t8pwm_pkg::VEC_CMPA)
    else $error("vector without pending interrupt");

  // A result without a taken acknowledge shows acknowledge vector zero
  a_ack_vec: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[13] |-> m_tdata[15:14] == t8pwm_pkg::VEC_CMPA)
    else $error("acknowledge vector without taken");

  // Vector code three is never produced
  a_vec_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[12:11] != 2'd3 && m_tdata[15:14] != 2'd3)
    else $error("vector out of range");

endmodule

bind timer8_pwm_counter t8pwm_checker u_t8pwm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: verif/timer8_pwm_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the timer, keeps its own copy of the timer
// state and compares every result transaction with the one predicted.
module timer8_pwm_checker
  import t8pwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          mismatch_count,
  output int          outstanding
);

  // Same order as m_tdata[18:0], highest bit first
  typedef struct packed {
    logic       ovf_event;
    logic       match_b_event;
    logic       match_a_event;
    logic [1:0] ack_vec;
    logic       ack_taken;
    logic [1:0] irq_vec;
    logic       irq_pending;
    logic       pin_b;
    logic       pin_a;
    logic [7:0] rd_data;
  } timer_result_t;

  timer_result_t due_results[$];
  timer_result_t want;
  timer_result_t got;

  logic       powered_down;
  logic [7:0] tcnt;
  logic [7:0] ocr_a, ocr_b;
  logic [7:0] ocr_a_buf, ocr_b_buf;
  logic [7:0] ctl_a, ctl_b;
  logic [7:0] irq_mask;
  logic [2:0] irq_flags;
  logic       count_up;
  logic [9:0] presc;
  logic       last_tpin;
  logic       pin_a, pin_b;
  logic       ev_a, ev_b, ev_ovf;

  function automatic logic [2:0] cur_mode();
    return {ctl_b[3], ctl_a[1:0]};
  endfunction

  function automatic logic slope_mode(input logic [2:0] m);
    return (m == MODE_PC_FF) || (m == MODE_PC_CMP_A);
  endfunction

  function automatic logic sawtooth_mode(input logic [2:0] m);
    return (m == MODE_FAST_FF) || (m == MODE_FAST_CMP_A);
  endfunction

  function automatic logic drive_pin(input logic level, input logic [1:0] act);
    case (act)
      ACT_TOGGLE: return ~level;
      ACT_CLEAR:  return 1'b0;
      ACT_SET:    return 1'b1;
      default:    return level;
    endcase
  endfunction

  // On the down slope clear and set swap roles
  function automatic logic [1:0] slope_action(input logic [1:0] act, input logic pc);
    if (pc && !count_up) begin
      if (act == ACT_CLEAR) return ACT_SET;
      if (act == ACT_SET) return ACT_CLEAR;
    end
    return act;
  endfunction

  function automatic logic [10:0] tick_divisor(input logic [2:0] cs);
    case (cs)
      CS_DIV8:    return 11'd8;
      CS_DIV64:   return 11'd64;
      CS_DIV256:  return 11'd256;
      CS_DIV1024: return 11'd1024;
      default:    return 11'd1;
    endcase
  endfunction

  function automatic void count_once();
    logic [2:0] m;
    logic [7:0] top;
    logic [1:0] act_a, act_b;
    logic       pc, fast;
    m     = cur_mode();
    pc    = slope_mode(m);
    fast  = sawtooth_mode(m);
    top   = (m == MODE_CTC || m == MODE_PC_CMP_A || m == MODE_FAST_CMP_A) ? ocr_a : 8'hFF;
    act_a = ctl_a[7:6];
    act_b = ctl_a[5:4];
    if (pc) begin
      if (count_up) begin
        if (tcnt == top) begin
          count_up = 1'b0;
          if (tcnt != 8'd0) tcnt = tcnt - 8'd1;
        end else begin
          tcnt = tcnt + 8'd1;
          if (tcnt == top) begin
            count_up = 1'b0;
            ocr_a = ocr_a_buf;
            ocr_b = ocr_b_buf;
          end
        end
      end else if (tcnt == 8'd0) begin
        count_up = 1'b1;
        irq_flags[FLAG_OVF] = 1'b1;
        ev_ovf = 1'b1;
        tcnt = 8'd1;
      end else begin
        tcnt = tcnt - 8'd1;
      end
    end else if (fast) begin
      if (tcnt == top) begin
        irq_flags[FLAG_OVF] = 1'b1;
        ev_ovf = 1'b1;
        ocr_a = ocr_a_buf;
        ocr_b = ocr_b_buf;
        tcnt = 8'd0;
      end else begin
        tcnt = tcnt + 8'd1;
      end
    end else begin
      if (tcnt == top) begin
        if (m != MODE_CTC) begin
          irq_flags[FLAG_OVF] = 1'b1;
          ev_ovf = 1'b1;
        end
        tcnt = 8'd0;
      end else begin
        tcnt = tcnt + 8'd1;
      end
    end

    if (tcnt == ocr_a) begin
      irq_flags[FLAG_CMPA] = 1'b1;
      ev_a = 1'b1;
      pin_a = drive_pin(pin_a, slope_action(act_a, pc));
    end
    if (tcnt == ocr_b) begin
      irq_flags[FLAG_CMPB] = 1'b1;
      ev_b = 1'b1;
      pin_b = drive_pin(pin_b, slope_action(act_b, pc));
    end
    // Fast PWM: restore the idle level at bottom
    if (fast && tcnt == 8'd0) begin
      if (act_a == ACT_CLEAR) pin_a = 1'b1;
      else if (act_a == ACT_SET) pin_a = 1'b0;
      if (act_b == ACT_CLEAR) pin_b = 1'b1;
      else if (act_b == ACT_SET) pin_b = 1'b0;
    end
  endfunction

  function automatic void clock_in(input logic tpin);
    logic [2:0] cs;
    logic       hit;
    cs = ctl_b[2:0];
    if (powered_down || cs == CS_STOP) return;
    if (cs <= CS_DIV1024) begin
      presc = presc + 10'd1;
      if ({1'b0, presc} >= tick_divisor(cs) || presc == 10'd0) begin
        presc = 10'd0;
        count_once();
      end
    end else begin
      hit = (cs == CS_FALL) ? (last_tpin && !tpin) : (!last_tpin && tpin);
      if (hit) count_once();
      last_tpin = tpin;
    end
  endfunction

  function automatic logic [7:0] read_reg(input logic [2:0] addr);
    case (addr)
      ADDR_COUNT:  return tcnt;
      ADDR_CMP_A:  return ocr_a_buf;
      ADDR_CMP_B:  return ocr_b_buf;
      ADDR_CTRL_A: return ctl_a;
      ADDR_CTRL_B: return ctl_b;
      ADDR_MASK:   return irq_mask;
      ADDR_FLAGS:  return {5'd0, irq_flags};
      default:     return 8'd0;
    endcase
  endfunction

  function automatic void write_reg(input logic [2:0] addr, input logic [7:0] v);
    logic direct;
    direct = !(slope_mode(cur_mode()) || sawtooth_mode(cur_mode())) || ctl_b[2:0] == CS_STOP;
    case (addr)
      ADDR_COUNT: tcnt = v;
      ADDR_CMP_A: begin
        ocr_a_buf = v;
        if (direct) ocr_a = v;
      end
      ADDR_CMP_B: begin
        ocr_b_buf = v;
        if (direct) ocr_b = v;
      end
      ADDR_CTRL_A: ctl_a = v;
      ADDR_CTRL_B: begin
        ctl_b = v & 8'h3F;
        if (!(slope_mode(cur_mode()) || sawtooth_mode(cur_mode()))) begin
          if (v[7]) pin_a = drive_pin(pin_a, ctl_a[7:6]);
          if (v[6]) pin_b = drive_pin(pin_b, ctl_a[5:4]);
        end
      end
      ADDR_MASK:  irq_mask = v;
      ADDR_FLAGS: irq_flags = irq_flags & ~v[2:0];
      default: ;
    endcase
  endfunction

  // Highest-priority enabled source; the vector reads as zero when none
  function automatic logic find_pending(output logic [1:0] vec);
    logic [2:0] live;
    live = irq_flags & irq_mask[2:0];
    vec = VEC_CMPA;
    if (live[FLAG_CMPA]) return 1'b1;
    vec = VEC_CMPB;
    if (live[FLAG_CMPB]) return 1'b1;
    vec = VEC_OVF;
    if (live[FLAG_OVF]) return 1'b1;
    vec = VEC_CMPA;
    return 1'b0;
  endfunction

  function automatic timer_result_t apply_item(input logic [1:0] op, input logic [2:0] addr,
                                               input logic [7:0] data, input logic tpin);
    timer_result_t r;
    logic [1:0]    vec;
    r = '0;
    ev_a = 1'b0;
    ev_b = 1'b0;
    ev_ovf = 1'b0;
    case (op)
      OP_TICK:  clock_in(tpin);
      OP_READ:  r.rd_data = read_reg(addr);
      OP_WRITE: write_reg(addr, data);
      default: begin
        r.ack_taken = find_pending(vec);
        if (r.ack_taken) begin
          r.ack_vec = vec;
          case (vec)
            VEC_CMPA: irq_flags[FLAG_CMPA] = 1'b0;
            VEC_CMPB: irq_flags[FLAG_CMPB] = 1'b0;
            default:  irq_flags[FLAG_OVF] = 1'b0;
          endcase
        end
      end
    endcase
    r.irq_pending   = find_pending(vec);
    r.irq_vec       = vec;
    r.pin_a         = pin_a;
    r.pin_b         = pin_b;
    r.match_a_event = ev_a;
    r.match_b_event = ev_b;
    r.ovf_event     = ev_ovf;
    return r;
  endfunction

  function automatic void reset_timer();
    powered_down = 1'b0;
    tcnt = '0;
    ocr_a = '0;
    ocr_b = '0;
    ocr_a_buf = '0;
    ocr_b_buf = '0;
    ctl_a = '0;
    ctl_b = '0;
    irq_mask = '0;
    irq_flags = '0;
    count_up = 1'b1;
    presc = '0;
    last_tpin = 1'b0;
    pin_a = 1'b0;
    pin_b = 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_timer();
      due_results.delete();
      mismatch_count = 0;
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) powered_down = cfg_data;
      if (m_tvalid && m_tready) begin
        got = m_tdata[18:0];
        if (due_results.size() == 0) begin
          $display("%0t: result %0h with none expected", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          check_field("rd_value", want.rd_data, got.rd_data);
          check_field("pin_a_level", 8'(want.pin_a), 8'(got.pin_a));
          check_field("pin_b_level", 8'(want.pin_b), 8'(got.pin_b));
          check_field("irq_pending", 8'(want.irq_pending), 8'(got.irq_pending));
          check_field("irq_vector", 8'(want.irq_vec), 8'(got.irq_vec));
          check_field("ack_taken", 8'(want.ack_taken), 8'(got.ack_taken));
          check_field("ack_vector", 8'(want.ack_vec), 8'(got.ack_vec));
          check_field("match_a_event", 8'(want.match_a_event), 8'(got.match_a_event));
          check_field("match_b_event", 8'(want.match_b_event), 8'(got.match_b_event));
          check_field("overflow_event", 8'(want.ovf_event), 8'(got.ovf_event));
        end
      end
      if (s_tvalid && s_tready) begin
        due_results.push_back(apply_item(s_tuser, s_tdata[2:0], s_tdata[10:3], s_tdata[11]));
      end
      outstanding = due_results.size();
    end
  end

endmodule

FILE: verif/tb_timer8_pwm_counter.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the 8-bit timer/counter. Prediction and comparison
// live in the checker instantiated beside the block.
module tb_timer8_pwm_counter;
  import t8pwm_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [2:0] ADDR_RESERVED = 3'd7;
  localparam logic [2:0] CS_RISE       = 3'd7;

  // Cycles without any transaction before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  // Length of the long hold-off on the result side
  localparam int HOLD_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  int mismatch_count;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;
  bit hold_start = 1'b0;

  always #5 clk = ~clk;

  timer8_pwm_counter i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  timer8_pwm_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  // Offer one item from a falling edge and hold it until the transaction
  // completes; return on the next falling edge.
  task automatic send_item(input logic [1:0] op, input logic [2:0] addr,
                           input logic [7:0] data, input logic tpin);
    // Insert random gaps before the item
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'd0, tpin, data, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic tick(input logic tpin);
    send_item(OP_TICK, ADDR_COUNT, 8'h00, tpin);
  endtask

  // Lower valid and wait until every result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Write the power-down bit; only called with the block idle
  task automatic set_power_down(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Bias write data towards values that make the counter do something:
  // fast clock selects, compare and count values near bottom and top.
  function automatic logic [7:0] pick_write_data(input logic [2:0] addr);
    int         r;
    logic [2:0] cs;
    r = $urandom_range(99);
    case (addr)
      ADDR_CTRL_B: begin
        if (r < 45) cs = CS_DIV1;
        else if (r < 60) cs = CS_FALL;
        else if (r < 75) cs = CS_RISE;
        else if (r < 85) cs = CS_DIV8;
        else if (r < 90) cs = CS_STOP;
        else cs = 3'($urandom_range(CS_DIV64, CS_DIV1024));
        // Force strobe bits drawn at random in about a quarter of the writes, clear in the rest
        return {(($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b00),
                2'($urandom_range(3)), 1'($urandom_range(1)), cs};
      end
      ADDR_COUNT, ADDR_CMP_A, ADDR_CMP_B: begin
        if (r < 40) return 8'($urandom_range(0, 7));
        if (r < 80) return 8'($urandom_range(248, 255));
        return 8'($urandom_range(255));
      end
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_item();
    int         r;
    logic [2:0] addr;
    r = $urandom_range(99);
    addr = 3'($urandom_range(7));
    if (r < 55) begin
      tick(1'($urandom_range(1)));
    end else if (r < 70) begin
      send_item(OP_READ, addr, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (r < 90) begin
      send_item(OP_WRITE, addr, pick_write_data(addr), 1'($urandom_range(1)));
    end else begin
      send_item(OP_ACK, addr, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // Result side: accept at random, with one long hold-off on request so
  // the output register fills and the input side stalls.
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Abandon the run when no transaction completes for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_power_down(1'b0);

    // Reserved address: read gives zero, write is dropped
    send_item(OP_READ, ADDR_RESERVED, 8'h00, 1'b0);
    send_item(OP_WRITE, ADDR_RESERVED, 8'hFF, 1'b1);
    send_item(OP_WRITE, ADDR_MASK, 8'hFF, 1'b0);
    // Normal mode, toggle on both channels; force both with the clock stopped
    send_item(OP_WRITE, ADDR_CTRL_A, {ACT_TOGGLE, ACT_TOGGLE, 4'h0}, 1'b0);
    send_item(OP_WRITE, ADDR_CTRL_B, 8'hC0, 1'b0);
    send_item(OP_READ, ADDR_CTRL_B, 8'h00, 1'b0);
    send_item(OP_WRITE, ADDR_CMP_A, 8'hFF, 1'b0);
    send_item(OP_WRITE, ADDR_CMP_B, 8'h00, 1'b0);
    send_item(OP_WRITE, ADDR_COUNT, 8'hFE, 1'b0);
    send_item(OP_WRITE, ADDR_CTRL_B, {5'd0, CS_DIV1}, 1'b0);
    // Reach top, then wrap: both compares, overflow, then acknowledge by priority
    tick(1'b1);
    tick(1'b0);
    send_item(OP_ACK, ADDR_COUNT, 8'h00, 1'b0);
    send_item(OP_ACK, ADDR_COUNT, 8'h00, 1'b0);
    send_item(OP_READ, ADDR_FLAGS, 8'h00, 1'b0);
    send_item(OP_WRITE, ADDR_FLAGS, 8'hFF, 1'b0);
    // Fast PWM to 0xFF with set on A and clear on B; compare A is buffered
    send_item(OP_WRITE, ADDR_CTRL_A, {ACT_SET, ACT_CLEAR, 2'b00, MODE_FAST_FF[1:0]}, 1'b0);
    send_item(OP_WRITE, ADDR_CMP_A, 8'h01, 1'b0);
    send_item(OP_READ, ADDR_CMP_A, 8'h00, 1'b0);
    send_item(OP_WRITE, ADDR_COUNT, 8'hFF, 1'b0);
    tick(1'b1);
    tick(1'b0);
    // Phase-correct to compare A on falling edges of the pin, clear on both
    send_item(OP_WRITE, ADDR_CTRL_A, {ACT_CLEAR, ACT_CLEAR, 2'b00, MODE_PC_CMP_A[1:0]}, 1'b0);
    send_item(OP_WRITE, ADDR_CTRL_B, {4'b0000, 1'b1, CS_FALL}, 1'b0);
    tick(1'b1);
    tick(1'b0);
    tick(1'b0);
    // Rising edges, unused control bits set
    send_item(OP_WRITE, ADDR_CTRL_B, 8'h3F, 1'b0);
    tick(1'b1);
    send_item(OP_WRITE, ADDR_CTRL_B, {5'd0, CS_STOP}, 1'b0);
    tick(1'b1);

    // Random traffic, sender lightly idle and receiver busy
    tx_idle_pct = 22;
    rx_idle_pct = 50;
    repeat (300) send_random_item();
    drain();

    // Powered down: ticks must leave the timer alone; swap the idling
    set_power_down(1'b1);
    tx_idle_pct = 50;
    rx_idle_pct = 22;
    repeat (200) send_random_item();
    drain();

    // Back on, full rate, with one long stall on the result side
    set_power_down(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_start = 1'b1;
    repeat (250) send_random_item();
    drain();

    // Allow the last result to settle before the verdict
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/t8pwm_pkg.sv
design/timer8_pwm_counter.sv
design/t8pwm_checker.sv
verif/timer8_pwm_checker.sv
verif/tb_timer8_pwm_counter.sv
